@@ sv/c2u_pkg.sv @@
`timescale 1ns / 1ps

package c2u_pkg;

    // Number of UTF-8 bytes a character takes.
    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    localparam logic [15:0] CYRILLIC_BASE = 16'h0410;

    // Code points for bytes 0x80 through 0xBF.
    localparam logic [15:0] UPPER_BLOCK [64] = '{
        16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
        16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h0000, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
        16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
        16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
        16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
        16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457
    };

    // One encoded character: seq[0] goes out first, len bytes are used.
    typedef struct packed {
        logic [2:0][7:0] seq;
        logic [1:0]      len;
    } utf8_char_t;

endpackage

@@ sv/c2u_encoder.sv @@
`timescale 1ns / 1ps

module c2u_encoder
(
    input  logic [7:0]          code_byte,
    output c2u_pkg::utf8_char_t enc
);

    logic [15:0] cp;

    always_comb
    begin
        if (code_byte inside {[8'h00:8'h7F]})
        begin
            cp = {8'h00, code_byte};
        end
        else if (code_byte inside {[8'hC0:8'hFF]})
        begin
            cp = c2u_pkg::CYRILLIC_BASE + {10'd0, code_byte[5:0]};
        end
        else
        begin
            cp = c2u_pkg::UPPER_BLOCK[code_byte[5:0]];
        end
    end

    always_comb
    begin
        if (cp[15:7] == 9'd0)
        begin
            enc.len = c2u_pkg::LEN_ONE;
            enc.seq = {8'h00, 8'h00, cp[7:0]};
        end
        else if (cp[15:11] == 5'd0)
        begin
            enc.len = c2u_pkg::LEN_TWO;
            enc.seq = {8'h00, {2'b10, cp[5:0]}, {3'b110, cp[10:6]}};
        end
        else
        begin
            enc.len = c2u_pkg::LEN_THREE;
            enc.seq = {{2'b10, cp[5:0]}, {2'b10, cp[11:6]}, {4'b1110, cp[15:12]}};
        end
    end

endmodule

@@ sv/c2u_serializer.sv @@
`timescale 1ns / 1ps

module c2u_serializer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  c2u_pkg::utf8_char_t enc,
    output logic                load_ready,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_byte,
    output logic                last_of_run
);

    logic            vld_reg;
    logic            vld_next;
    logic [1:0]      rem_reg;
    logic [1:0]      rem_next;
    logic [2:0][7:0] seq_reg;
    logic [2:0][7:0] seq_next;
    logic            pop;
    logic            last;

    assign last        = (rem_reg == c2u_pkg::LEN_ONE);
    assign pop         = vld_reg && !out_stall;
    assign load_ready  = !vld_reg || (pop && last);
    assign out_valid   = vld_reg;
    assign out_byte    = seq_reg[0];
    assign last_of_run = last;

    always_comb
    begin
        vld_next = vld_reg;
        rem_next = rem_reg;
        seq_next = seq_reg;
        if (load)
        begin
            vld_next = 1'b1;
            rem_next = enc.len;
            seq_next = enc.seq;
        end
        else if (pop)
        begin
            if (last)
            begin
                vld_next = 1'b0;
            end
            else
            begin
                rem_next = rem_reg - 2'd1;
                seq_next = {8'h00, seq_reg[2], seq_reg[1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            rem_reg <= 2'd0;
        end
        else
        begin
            vld_reg <= vld_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg <= seq_next;
    end

    // A held character always has at least one byte left to send.
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg |-> (rem_reg != 2'd0))
        else $error("serializer holds a character with no bytes left");

    // Taking a byte that is not the last one leaves the character in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !last) |=> vld_reg)
        else $error("character dropped before its last byte");

endmodule

@@ sv/cp1251_to_utf8_transcoder.sv @@
`timescale 1ns / 1ps

// Windows-1251 to UTF-8 transcoder.
// Input channel: in_valid / in_stall with code_byte, one Windows-1251
// character per transaction. Output channel: out_valid / out_stall with
// out_byte and last_of_run, one UTF-8 byte per transaction, the first byte
// of a character first and last_of_run set on its final byte.
// A character is encoded as one, two or three bytes depending on its code
// point; the undefined byte 0x98 and byte 0x00 both give a single 0x00 byte.
// An input character is registered in the input register and then in the
// serializer before its first byte reaches the output.
// Throughput: the output port moves one byte per cycle while out_stall is low,
// so a character takes one, two or three output transactions; ASCII runs at one per cycle.
// An input register holds the next character while the serializer sends the
// current one, so input is taken while output is still in progress.
// Reset clears both valid flags and the serializer's byte count; the data registers are not reset.
// When the receiver stalls, the current byte holds, and once the input
// register is full, in_stall rises until the serializer frees up.

module cp1251_to_utf8_transcoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] code_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic                in_vld_reg;
    logic                in_vld_next;
    logic [7:0]          code_reg;
    logic [7:0]          code_next;
    logic                accept;
    logic                advance;
    logic                load_ready;
    c2u_pkg::utf8_char_t enc;

    assign advance  = in_vld_reg && load_ready;
    assign in_stall = in_vld_reg && !load_ready;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        code_next   = code_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
            code_next   = code_byte;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    c2u_encoder u_encoder
    (
        .code_byte (code_reg),
        .enc       (enc)
    );

    c2u_serializer u_serializer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .enc         (enc),
        .load_ready  (load_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    // Input is held back only while a character waits in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg)
        else $error("input stalled with an empty input register");

    // A character handed to the serializer shows up on the output next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("character moved on but no output byte follows");

endmodule
